// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the walker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted (active low).
`define NPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define NPT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== sv/npt_pkg.sv =====
// ----------------------------------------------------------------------------
// npt_pkg
// Shared widths, codes and state types for the nested page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package npt_pkg;

  // Table store geometry
  localparam int TABLE_PAGES     = 16;
  localparam int SLOT_W          = 9;
  localparam int SLOTS_PER_TABLE = 512;
  localparam int STORE_WORDS     = TABLE_PAGES * SLOTS_PER_TABLE;
  localparam int STORE_AW        = $clog2(STORE_WORDS);
  localparam int FRAME_W         = $clog2(TABLE_PAGES);

  // Field widths
  localparam int GA_W     = 48;
  localparam int HA_W     = 52;
  localparam int IDX_W    = 13;
  localparam int ENTRY_W  = 64;
  localparam int ROOT_W   = 4;
  localparam int PFN_W    = 40;
  localparam int OFFSET_W = 12;
  localparam int STATUS_W = 2;
  localparam int LEVEL_W  = 2;

  // Config port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_ROOT_TABLE_FRAME = 1'b0;  // word index, paddr[2]

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_ROOT = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_DIR  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_LEAF = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NOT_PRESENT  = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } npt_status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } npt_state_t;

endpackage

`default_nettype wire

// ===== sv/npt_in_if.sv =====
// ----------------------------------------------------------------------------
// npt_in_if
// Input channel: table writes and translate requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface npt_in_if
  import npt_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [GA_W-1:0]    guest_address;
  logic [IDX_W-1:0]   entry_index;
  logic [ENTRY_W-1:0] entry_value;

  modport source (output valid, mode, guest_address, entry_index, entry_value,
                  input ready);
  modport sink   (input valid, mode, guest_address, entry_index, entry_value,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/npt_out_if.sv =====
// ----------------------------------------------------------------------------
// npt_out_if
// Result channel: translated address with status.
// ----------------------------------------------------------------------------
`default_nettype none

interface npt_out_if
  import npt_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [HA_W-1:0]     host_address;
  logic [STATUS_W-1:0] status;
  logic [LEVEL_W-1:0]  fault_level;

  modport source (output valid, host_address, status, fault_level, input ready);
  modport sink   (input valid, host_address, status, fault_level, output ready);
endinterface

`default_nettype wire

// ===== sv/nested_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// nested_page_table_walker
// Four-level extended page table walker over an on-chip table store.
// ----------------------------------------------------------------------------
// The walker holds TABLE_PAGES frames of 512 64-bit entries in one synchronous
// RAM. After reset it runs a clearing pass over all STORE_WORDS entries (8192
// at 16 pages) that zeroes the store; no input beat is taken until it ends,
// while config writes are taken throughout. A write beat (mode 0) stores one
// entry; it returns nothing. A translate beat (mode 1) issues the root read in
// its accept cycle, then at each level checks the returned entry and issues
// the next read, until the leaf or a fault loads the result. The next beat
// can be taken in the cycle after the load, so a walk holds the input until
// its result is loaded. The bound is the single RAM read port and the chain
// of four dependent reads. The result sits in an output register, so the next
// beat is accepted while it waits; only a finished walk stalls if the previous
// result has not yet been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_page_table_walker
  import npt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  npt_in_if.sink                 in_ch,
  npt_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ROOT_TABLE_FRAME);
  assign root_nxt = cfg_wr ? pwdata[ROOT_W-1:0] : root_r;
  assign prdata = (paddr[2] == REG_ROOT_TABLE_FRAME) ? CFG_DW'(root_r) : '0;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  npt_state_t           state_r, state_nxt;
  logic [STORE_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic                 root_bad_r, root_bad_nxt;
  logic [GA_W-1:0]      ga_r, ga_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [HA_W-1:0]      out_host_r, out_host_nxt;
  npt_status_t          out_status_r, out_status_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;

  // RAM port
  logic                 ram_we, ram_re;
  logic [STORE_AW-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

  npt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Walk datapath: rdata holds the entry for level lvl_r
  // --------------------------------------------------------------------------
  logic               in_acc;
  logic               wr_in_range;
  logic               root_out;
  logic [STORE_AW-1:0] root_addr;
  logic [PFN_W-1:0]   next_pfn;
  logic [SLOT_W-1:0]  next_slot;
  logic [STORE_AW-1:0] next_addr;
  logic               at_leaf, fault_np, fault_oor, walk_done, out_free;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign wr_in_range = 32'(in_ch.entry_index) < 32'(STORE_WORDS);
  assign root_out    = int'(root_r) >= TABLE_PAGES;
  // Root frame is truncated when out of range; that read result is discarded.
  assign root_addr   = STORE_AW'({FRAME_W'(root_r), in_ch.guest_address[47:39]});

  assign next_pfn  = ram_rdata[51:12];
  assign at_leaf   = (lvl_r == LVL_LEAF);
  assign fault_np  = !at_leaf && (next_pfn == '0);
  assign fault_oor = !at_leaf && (next_pfn >= PFN_W'(TABLE_PAGES));
  assign walk_done = root_bad_r || at_leaf || fault_np || fault_oor;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Index of the level after lvl_r
  always_comb begin
    case (lvl_r)
      LVL_ROOT: next_slot = ga_r[38:30];
      LVL_PDPT: next_slot = ga_r[29:21];
      LVL_DIR:  next_slot = ga_r[20:12];
      default:  next_slot = '0;
    endcase
  end

  assign next_addr = STORE_AW'({next_pfn[FRAME_W-1:0], next_slot});

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    lvl_nxt        = lvl_r;
    root_bad_nxt   = root_bad_r;
    ga_nxt         = ga_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_host_nxt   = out_host_r;
    out_status_nxt = out_status_r;
    out_level_nxt  = out_level_r;

    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == STORE_AW'(STORE_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc && (in_ch.mode == MODE_XLATE)) begin
          state_nxt    = S_WALK;
          lvl_nxt      = LVL_ROOT;
          root_bad_nxt = root_out;
          ga_nxt       = in_ch.guest_address;
        end
      end
      S_WALK: begin
        if (!walk_done) begin
          lvl_nxt = lvl_r + 1'b1;
        end else if (out_free) begin
          // Load result; stall here otherwise, rdata holds with no read
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_host_nxt  = '0;
          out_level_nxt = lvl_r;
          if (root_bad_r) begin
            out_status_nxt = ST_OUT_OF_RANGE;
            out_level_nxt  = LVL_ROOT;
          end else if (at_leaf) begin
            out_status_nxt = ST_OK;
            out_level_nxt  = LVL_ROOT;
            out_host_nxt   = {next_pfn, ga_r[OFFSET_W-1:0]};
          end else if (fault_np) begin
            out_status_nxt = ST_NOT_PRESENT;
          end else begin
            out_status_nxt = ST_OUT_OF_RANGE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: handshake and RAM controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_r;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = next_addr;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        // ready is high throughout idle, so valid alone marks a beat
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.mode == MODE_WRITE) begin
            ram_we    = wr_in_range;
            ram_waddr = STORE_AW'(in_ch.entry_index);
            ram_wdata = in_ch.entry_value;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = root_addr;
          end
        end
      end
      S_WALK: begin
        ram_re = !walk_done;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.host_address = out_host_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.fault_level  = out_level_r;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      lvl_r       <= LVL_ROOT;
      root_bad_r  <= 1'b0;
      out_valid_r <= 1'b0;
      root_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      lvl_r       <= lvl_nxt;
      root_bad_r  <= root_bad_nxt;
      out_valid_r <= out_valid_nxt;
      root_r      <= root_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    ga_r         <= ga_nxt;
    out_host_r   <= out_host_nxt;
    out_status_r <= out_status_nxt;
    out_level_r  <= out_level_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/npt_ram.sv =====
// ----------------------------------------------------------------------------
// npt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module npt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/npt_checker.sv =====
// ----------------------------------------------------------------------------
// npt_checker
// Port-level assertions for the walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module npt_checker
  import npt_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_mode,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [HA_W-1:0]     out_host_address,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [LEVEL_W-1:0]  out_fault_level
);

  // Store clear runs after reset, so no beat is taken right after it.
  `NPT_ASSERT_NR(a_busy_after_reset, clk, (!rst_n |=> !in_ready), "ready right after reset")

  // A stalled result beat holds.
  `NPT_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid && $stable(out_host_address) && $stable(out_status) && $stable(out_fault_level)), "result beat changed while stalled")

  // A table write makes no result.
  `NPT_ASSERT(a_write_silent, clk, rst_n, (in_valid && in_ready && (in_mode == MODE_WRITE) && !out_valid |=> !out_valid), "result after a write beat")

  // An accepted translation leaves the walker busy, with ready low.
  `NPT_ASSERT(a_walk_busy, clk, rst_n, (in_valid && in_ready && (in_mode == MODE_XLATE) |=> !in_ready), "ready right after a translate beat")

  // Success has no fault level; a fault has a zero address.
  `NPT_ASSERT(a_result_shape, clk, rst_n, (out_valid |-> ((out_status == ST_OK) && (out_fault_level == LVL_ROOT)) || (((out_status == ST_NOT_PRESENT) || (out_status == ST_OUT_OF_RANGE)) && (out_host_address == '0))), "malformed result beat")

endmodule

bind nested_page_table_walker npt_checker u_npt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_mode          (in_ch.mode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_host_address (out_ch.host_address),
  .out_status       (out_ch.status),
  .out_fault_level  (out_ch.fault_level)
);

`default_nettype wire

// ===== tb/tb_nested_page_table_walker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nested_page_table_walker
// Self-checking bench for the four-level nested page table walker.
// ----------------------------------------------------------------------------
// Table writes and translate requests go in through the input channel. A
// shadow copy of the table store and the root register predicts every walk
// when its beat is accepted. Each result beat is checked field by field
// against the oldest pending prediction. The run goes through several root
// frame settings. Each setting gets a mix of well-formed four-level mappings,
// re-walks of mapped addresses with changed slots or offsets, and chains
// broken with absent or out-of-store frames, plus random noise.
// ----------------------------------------------------------------------------

module tb_nested_page_table_walker
  import npt_pkg::*;
;

  localparam int N_PHASES     = 5;
  localparam int RAND_PER_PH  = 100;   // random beats per root setting
  localparam int SETTLE_CYC   = 8;     // longest walk plus margin
  localparam int MAPPED_KEEP  = 32;    // recently mapped addresses kept for re-walks

  // byte address of the root frame register: word index in paddr[2]
  localparam logic [CFG_AW-1:0] ADDR_ROOT = {REG_ROOT_TABLE_FRAME, 2'b00};

  typedef struct packed {
    logic               mode;
    logic [GA_W-1:0]    ga;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] value;
  } walk_req_t;

  typedef struct packed {
    logic [HA_W-1:0]    host_address;
    npt_status_t        status;
    logic [LEVEL_W-1:0] fault_level;
  } xlate_result_t;

  logic clk;
  logic rst_n;

  // config port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  npt_in_if  in_ch();
  npt_out_if out_ch();

  nested_page_table_walker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's state
  logic [ENTRY_W-1:0] store_model [STORE_WORDS];
  logic [ROOT_W-1:0]  root_model;

  walk_req_t       pending_reqs[$];     // beats not yet presented
  xlate_result_t   expected_xlates[$];  // predictions waiting for their result
  logic [GA_W-1:0] mapped_gas[$];       // addresses with a full mapping built

  walk_req_t     drive_req;
  xlate_result_t want;
  int gap_max;
  int stall_max;
  int gap_left;
  int stall_left;
  int errors;
  int n_writes;
  int n_ok;
  int n_absent;
  int n_outside;

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Walk predictor: root -> directory pointer -> directory -> leaf.
  // Levels 0..2 fault on a zero frame or a frame past the store; the leaf frame
  // is used unchecked, zero included.
  // --------------------------------------------------------------------------
  function automatic xlate_result_t walk_predict(input logic [GA_W-1:0] ga);
    xlate_result_t      r;
    logic [PFN_W-1:0]   frame;
    logic [PFN_W-1:0]   next;
    logic [ENTRY_W-1:0] ent;
    r.host_address = '0;
    r.status       = ST_OK;
    r.fault_level  = LVL_ROOT;
    frame = PFN_W'(root_model);
    if (frame >= TABLE_PAGES) begin
      r.status = ST_OUT_OF_RANGE;
      return r;
    end
    for (int lv = 0; lv < 4; lv++) begin
      ent  = store_model[{frame[FRAME_W-1:0], ga[39-9*lv +: SLOT_W]}];
      next = ent[OFFSET_W +: PFN_W];
      if (lv == 3) begin
        r.host_address = {next, ga[OFFSET_W-1:0]};
        return r;
      end
      if (next == '0) begin
        r.status      = ST_NOT_PRESENT;
        r.fault_level = LEVEL_W'(lv);
        return r;
      end
      if (next >= TABLE_PAGES) begin
        r.status      = ST_OUT_OF_RANGE;
        r.fault_level = LEVEL_W'(lv);
        return r;
      end
      frame = next;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [GA_W-1:0] rand_ga();
    return GA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_entry();
    return {$urandom, $urandom};
  endfunction

  // entry pointing at a frame, with random flag bits around it
  function automatic logic [ENTRY_W-1:0] pte(input logic [PFN_W-1:0] frame);
    return {12'($urandom), frame, 12'($urandom)};
  endfunction

  function automatic void push_req(input logic m, input logic [GA_W-1:0] ga,
                                   input logic [IDX_W-1:0] idx,
                                   input logic [ENTRY_W-1:0] value);
    walk_req_t r;
    r.mode  = m;
    r.ga    = ga;
    r.idx   = idx;
    r.value = value;
    pending_reqs.push_back(r);
  endfunction

  // Map ga through fresh entries, four for a full chain, then translate it. A
  // bad_level of 0..2 ends the chain there with an absent or out-of-store frame.
  function automatic void push_walk(input logic [GA_W-1:0] ga, input int bad_level);
    logic [PFN_W-1:0] frame;
    logic [PFN_W-1:0] next;
    int               last;
    frame = PFN_W'(root_model);
    last  = (bad_level < 0) ? 3 : bad_level;
    for (int lv = 0; lv <= last; lv++) begin
      if (lv == bad_level) begin
        if ($urandom_range(0, 1) == 0) begin
          next = '0;
        end else begin
          next = PFN_W'({$urandom, $urandom}) >> $urandom_range(0, 35);
          if (next < TABLE_PAGES) next = PFN_W'(TABLE_PAGES);
        end
      end else if (lv == 3) begin
        // leaf: any frame, small ones and zero included
        next = PFN_W'({$urandom, $urandom}) >> $urandom_range(0, 40);
      end else begin
        next = PFN_W'($urandom_range(1, TABLE_PAGES - 1));
      end
      push_req(MODE_WRITE, rand_ga(), {frame[FRAME_W-1:0], ga[39-9*lv +: SLOT_W]},
               pte(next));
      frame = next;
    end
    push_req(MODE_XLATE, ga, IDX_W'($urandom), rand_entry());
    if (bad_level < 0) begin
      mapped_gas.push_back(ga);
      if (mapped_gas.size() > MAPPED_KEEP) void'(mapped_gas.pop_front());
    end
  endfunction

  // Hand-picked cases; assumes root frame 0 and a freshly cleared store.
  function automatic void push_directed();
    // empty store: root entry absent for both address extremes
    push_req(MODE_XLATE, '0, '0, '0);
    push_req(MODE_XLATE, '1, '1, '1);
    // all-ones address through frames 1, 2, 3 to an all-ones leaf
    push_req(MODE_WRITE, '0, {4'd0, 9'd511}, pte(40'd1));
    push_req(MODE_WRITE, '0, {4'd1, 9'd511}, pte(40'd2));
    push_req(MODE_WRITE, '0, {4'd2, 9'd511}, pte(40'd3));
    push_req(MODE_WRITE, '0, {4'd3, 9'd511}, '1);
    push_req(MODE_XLATE, '1, '0, '0);
    // leaf entry left at zero: walk succeeds with frame zero
    push_req(MODE_WRITE, '1, {4'd0, 9'd0}, pte(40'd4));
    push_req(MODE_WRITE, '1, {4'd4, 9'd0}, pte(40'd5));
    push_req(MODE_WRITE, '1, {4'd5, 9'd0}, pte(40'd15));
    push_req(MODE_XLATE, 48'h0000_0000_0ABC, '1, '1);
    // root entry names the first frame past the store
    push_req(MODE_WRITE, '0, {4'd0, 9'd5}, pte(40'd16));
    push_req(MODE_XLATE, {9'd5, 39'd0}, '0, '0);
    // directory pointer entry all ones: frame far out of the store
    push_req(MODE_WRITE, '0, {4'd0, 9'd7}, pte(40'd1));
    push_req(MODE_WRITE, '0, {4'd1, 9'd8}, '1);
    push_req(MODE_XLATE, {9'd7, 9'd8, 30'd0}, '0, '0);
    // directory entry never written: absent at level 2
    push_req(MODE_WRITE, '0, {4'd1, 9'd9}, pte(40'd2));
    push_req(MODE_XLATE, {9'd7, 9'd9, 9'd100, 21'd0}, '0, '0);
    // zero frame with every flag bit set is still absent
    push_req(MODE_WRITE, '0, {4'd0, 9'd6}, 64'hFFF0_0000_0000_0FFF);
    push_req(MODE_XLATE, {9'd6, 39'hFF_FFFF_FFFF}, '0, '0);
  endfunction

  // Random mix until the queue holds n beats. Filling takes no sim time.
  task automatic fill_random(input int n);
    int              kind;
    int              lv;
    logic [GA_W-1:0] ga;
    while (pending_reqs.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 50 || mapped_gas.size() == 0) begin
        push_walk(rand_ga(), -1);
      end else if (kind < 72) begin
        // re-walk a mapped address, one slot or the offset changed
        ga = mapped_gas[$urandom_range(0, mapped_gas.size() - 1)];
        lv = $urandom_range(0, 4);
        if (lv == 4) ga[OFFSET_W-1:0] = 12'($urandom);
        else ga[39-9*lv +: SLOT_W] = 9'($urandom);
        push_req(MODE_XLATE, ga, IDX_W'($urandom), rand_entry());
      end else if (kind < 84) begin
        push_walk(rand_ga(), $urandom_range(0, 2));
      end else if (kind < 92) begin
        push_req(MODE_WRITE, rand_ga(), IDX_W'($urandom), rand_entry());
      end else begin
        push_req(MODE_XLATE, rand_ga(), IDX_W'($urandom), rand_entry());
      end
    end
  endtask

  // Sampled on the falling edge so all clocked updates have settled.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_xlates.size() != 0)
      @(negedge clk);
    // last beat may be a write still landing in the store
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // Write the root frame register, then read it back.
  task automatic write_root(input logic [ROOT_W-1:0] frame);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ROOT;
    pwdata  <= CFG_DW'(frame);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    root_model = frame;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DW'(frame)) begin
      $display("%0t: root frame readback expected %h actual %h", $time,
               CFG_DW'(frame), prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Input driver. Predicts at acceptance, then presents the next beat after
  // its drawn gap. valid gets one assignment per edge, so back-to-back beats
  // keep it high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_WRITE) begin
          if (in_ch.entry_index < STORE_WORDS)
            store_model[in_ch.entry_index] = in_ch.entry_value;
          n_writes++;
        end else begin
          expected_xlates.push_back(walk_predict(in_ch.guest_address));
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          drive_req = pending_reqs.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.mode          <= drive_req.mode;
          in_ch.guest_address <= drive_req.ga;
          in_ch.entry_index   <= drive_req.idx;
          in_ch.entry_value   <= drive_req.value;
          gap_left = $urandom_range(0, gap_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Checks each beat against the oldest prediction, then
  // holds ready low for a drawn number of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_xlates.size() == 0) begin
          $display("%0t: result with no walk pending: host_address %h status %0d level %0d",
                   $time, out_ch.host_address, out_ch.status, out_ch.fault_level);
          errors++;
        end else begin
          want = expected_xlates.pop_front();
          if (out_ch.host_address !== want.host_address) begin
            $display("%0t: host_address expected %h actual %h", $time,
                     want.host_address, out_ch.host_address);
            errors++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_ch.status);
            errors++;
          end
          if (out_ch.fault_level !== want.fault_level) begin
            $display("%0t: fault_level expected %0d actual %0d", $time,
                     want.fault_level, out_ch.fault_level);
            errors++;
          end
          case (want.status)
            ST_OK:          n_ok++;
            ST_NOT_PRESENT: n_absent++;
            default:        n_outside++;
          endcase
        end
        stall_left = $urandom_range(0, stall_max);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, then one phase per root setting. Each phase after the
  // first is entered with the block idle; the register write lands during the
  // clearing pass for the first phase.
  // --------------------------------------------------------------------------
  initial begin
    logic [ROOT_W-1:0] root_plan [N_PHASES];
    int                gap_plan  [N_PHASES];
    int                stall_plan[N_PHASES];

    clk                 = 1'b0;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_WRITE;
    in_ch.guest_address = '0;
    in_ch.entry_index   = '0;
    in_ch.entry_value   = '0;
    out_ch.ready        = 1'b0;
    errors = 0; n_writes = 0; n_ok = 0; n_absent = 0; n_outside = 0;
    gap_max = 0; stall_max = 0;
    root_model = '0;
    for (int i = 0; i < STORE_WORDS; i++) store_model[i] = '0;

    // both extremes, two random frames, then back to zero
    root_plan  = '{4'd0, 4'd15, ROOT_W'($urandom_range(1, 14)),
                   ROOT_W'($urandom), 4'd0};
    gap_plan   = '{5, 0, 5, 0, 3};   // phase 1 runs flat out
    stall_plan = '{5, 0, 0, 5, 3};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_PHASES; p++) begin
      gap_max   = gap_plan[p];
      stall_max = stall_plan[p];
      write_root(root_plan[p]);
      if (p == 0) push_directed();
      fill_random(pending_reqs.size() + RAND_PER_PH);
      wait_idle();
    end

    $display("walks checked: %0d ok, %0d not present, %0d outside store; %0d table writes",
             n_ok, n_absent, n_outside, n_writes);
    $display("%0d root frame settings, idle and stall gaps of 0 to 5 cycles", N_PHASES);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: clearing pass plus the slowest run, many times over.
  initial begin
    #400000;
    $display("timeout with %0d beats queued, %0d results outstanding",
             pending_reqs.size(), expected_xlates.size());
    $display("status: fail");
    $finish;
  end

endmodule
